// File: rtl/mrt_pkg.sv
`default_nettype none

package mrt_pkg;

  // Table depth used when the top level is not told otherwise.
  localparam int unsigned NUM_REGIONS_DEF = 128;

  // Field widths of the request and response items.
  localparam int unsigned REQ_TYPE_W = 2;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned GROUP_W    = 14;
  localparam int unsigned HPTE_V_W   = 48;
  localparam int unsigned HPTE_R_W   = 64;

  // 4 KiB pages: the page frame number is the address from bit 12 upward.
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PFN_W      = ADDR_W - PAGE_SHIFT;

  // WIMG attributes: plain cacheable memory, or guarded and cache-inhibited I/O.
  localparam logic [2:0] WIMG_CACHED = 3'h2;
  localparam logic [2:0] WIMG_MMIO   = 3'h5;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_DEL   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_XLATE = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DISABLED = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic quick;
    logic hit;
    logic miss;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/mrt_ifs.sv
`default_nettype none

// Request channel: one table operation or translation per item.
interface mrt_req_if;
  logic                                valid;
  logic                                ready;
  logic [mrt_pkg::REQ_TYPE_W-1:0]      req_type;
  logic [mrt_pkg::ADDR_W-1:0]          addr;
  logic [mrt_pkg::SIZE_W-1:0]          size;

  modport source (output valid, req_type, addr, size, input ready);
  modport sink   (input valid, req_type, addr, size, output ready);
endinterface

// Response channel: one result item per request item.
interface mrt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [mrt_pkg::STATUS_W-1:0]        status;
  logic                                is_mmio;
  logic [mrt_pkg::GROUP_W-1:0]         pteg_slot;
  logic [mrt_pkg::HPTE_V_W-1:0]        hpte_v;
  logic [mrt_pkg::HPTE_R_W-1:0]        hpte_r;

  modport source (output valid, status, is_mmio, pteg_slot, hpte_v, hpte_r, input ready);
  modport sink   (input valid, status, is_mmio, pteg_slot, hpte_v, hpte_r, output ready);
endinterface

// Configuration write channel for the MMU enable register.
interface mrt_cfg_if;
  logic valid;
  logic ready;
  logic mmu_enabled;

  modport source (output valid, mmu_enabled, input ready);
  modport sink   (input valid, mmu_enabled, output ready);
endinterface

`default_nettype wire

// File: rtl/mrt_ctrl.sv
`default_nettype none

module mrt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire mrt_pkg::stat_t stat,
  output mrt_pkg::cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state, commands and output valid.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.quick ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.miss) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // No request is taken while reset is held.
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/mrt_dpath.sv
`default_nettype none

module mrt_dpath #(
  parameter int unsigned NUM_REGIONS = mrt_pkg::NUM_REGIONS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mrt_pkg::cmd_t                      cmd,
  output mrt_pkg::stat_t                          stat,
  input  wire logic [mrt_pkg::REQ_TYPE_W-1:0]     in_req_type,
  input  wire logic [mrt_pkg::ADDR_W-1:0]         in_addr,
  input  wire logic [mrt_pkg::SIZE_W-1:0]         in_size,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_mmu_enabled,
  output logic [mrt_pkg::STATUS_W-1:0]            out_status,
  output logic                                    out_is_mmio,
  output logic [mrt_pkg::GROUP_W-1:0]             out_pteg_slot,
  output logic [mrt_pkg::HPTE_V_W-1:0]            out_hpte_v,
  output logic [mrt_pkg::HPTE_R_W-1:0]            out_hpte_r
);

  localparam int unsigned AW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int unsigned IW    = $clog2(NUM_REGIONS + 1);
  localparam int unsigned AD_W  = mrt_pkg::ADDR_W;
  localparam int unsigned PFN_W = mrt_pkg::PFN_W;
  localparam int unsigned PS    = mrt_pkg::PAGE_SHIFT;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_REGIONS);

  // Region store: start and exclusive end per slot, plus a valid bit per slot.
  logic [AD_W-1:0]        start_mem [NUM_REGIONS];
  logic [AD_W-1:0]        end_mem   [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] valid_r;

  logic                   mmu_en_r;
  mrt_pkg::req_type_t     req_type_r;
  logic [PFN_W-1:0]       pfn_r;
  logic [AD_W-1:0]        hi_raw_r;

  // Scan pointer and the registered read of one slot.
  logic [IW-1:0]          idx_r;
  logic                   rd_vld_r;
  logic [AW-1:0]          rd_idx_r;
  logic [AD_W-1:0]        start_rd_r;
  logic [AD_W-1:0]        end_rd_r;
  logic                   valid_rd_r;

  // Result held until the output register is free, and the output register.
  mrt_pkg::status_t       res_status_r;
  logic                   res_mmio_r;
  logic [mrt_pkg::GROUP_W-1:0]  res_group_r;
  logic [mrt_pkg::HPTE_V_W-1:0] res_v_r;
  logic [mrt_pkg::HPTE_R_W-1:0] res_r_r;
  mrt_pkg::status_t       out_status_r;
  logic                   out_mmio_r;
  logic [mrt_pkg::GROUP_W-1:0]  out_group_r;
  logic [mrt_pkg::HPTE_V_W-1:0] out_v_r;
  logic [mrt_pkg::HPTE_R_W-1:0] out_r_r;

  logic [AD_W-1:0]        page_full;
  logic [AD_W-1:0]        hi_up;
  logic [PFN_W-1:0]       in_pfn;
  logic                   issue_en;
  logic                   match;
  logic                   mem_we;
  logic                   quick_req;
  logic                   scan_hit;
  logic                   scan_miss;
  mrt_pkg::status_t       quick_status;
  mrt_pkg::status_t       scan_status;
  logic [10:0]            hash;

  assign page_full = {pfn_r, {PS{1'b0}}};
  assign in_pfn    = in_addr[AD_W-1:PS];
  // Round the range end up to the next page boundary, wrapping modulo 2^64.
  assign hi_up     = {hi_raw_r[AD_W-1:PS] + {{(PFN_W-1){1'b0}}, |hi_raw_r[PS-1:0]},
                      {PS{1'b0}}};
  assign issue_en  = cmd.scan && (idx_r != LAST_IDX);
  assign hash      = pfn_r[26:16] ^ pfn_r[10:0];

  // Slot match for the operation being scanned.
  always_comb begin
    case (req_type_r)
      mrt_pkg::REQ_ADD:   match = !valid_rd_r;
      mrt_pkg::REQ_DEL:   match = valid_rd_r && (start_rd_r == page_full);
      mrt_pkg::REQ_XLATE: match = valid_rd_r && (start_rd_r <= page_full) &&
                                  (end_rd_r > page_full);
      default:            match = 1'b0;
    endcase
  end

  assign scan_hit  = cmd.scan && rd_vld_r && match;
  assign scan_miss = cmd.scan && !rd_vld_r && (idx_r == LAST_IDX);
  assign mem_we    = scan_hit && (req_type_r == mrt_pkg::REQ_ADD);
  assign stat      = '{quick: quick_req, hit: scan_hit, miss: scan_miss};

  // Requests answered without a table walk.
  always_comb begin
    quick_req    = 1'b0;
    quick_status = mrt_pkg::ST_OK;
    case (in_req_type)
      mrt_pkg::REQ_ADD: begin
        quick_req    = (in_size == '0) || (in_pfn == '0);
        quick_status = mrt_pkg::ST_BAD;
      end
      mrt_pkg::REQ_DEL: begin
        quick_req    = (in_pfn == '0);
        quick_status = mrt_pkg::ST_NOTFOUND;
      end
      mrt_pkg::REQ_CLEAR: begin
        quick_req    = 1'b1;
        quick_status = mrt_pkg::ST_OK;
      end
      mrt_pkg::REQ_XLATE: begin
        quick_req    = !mmu_en_r;
        quick_status = mrt_pkg::ST_DISABLED;
      end
      default: begin
        quick_req    = 1'b0;
        quick_status = mrt_pkg::ST_OK;
      end
    endcase
  end

  // Status at the end of a table walk.
  always_comb begin
    case (req_type_r)
      mrt_pkg::REQ_ADD: scan_status = scan_hit ? mrt_pkg::ST_OK : mrt_pkg::ST_FULL;
      mrt_pkg::REQ_DEL: scan_status = scan_hit ? mrt_pkg::ST_OK : mrt_pkg::ST_NOTFOUND;
      default:          scan_status = mrt_pkg::ST_OK;
    endcase
  end

  // Control state: enable register, valid bits and scan pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mmu_en_r <= 1'b0;
      valid_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mmu_en_r <= cfg_mmu_enabled;
      end
      if (cmd.accept && (in_req_type == mrt_pkg::REQ_CLEAR)) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[rd_idx_r] <= 1'b1;
      end else if (scan_hit && (req_type_r == mrt_pkg::REQ_DEL)) begin
        valid_r[rd_idx_r] <= 1'b0;
      end
      if (cmd.accept) begin
        idx_r <= '0;
      end else if (issue_en) begin
        idx_r <= idx_r + IW'(1);
      end
      rd_vld_r <= issue_en;
    end
  end

  // Region memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      start_mem[rd_idx_r] <= page_full;
      end_mem[rd_idx_r]   <= hi_up;
    end
    if (issue_en) begin
      start_rd_r <= start_mem[idx_r[AW-1:0]];
      end_rd_r   <= end_mem[idx_r[AW-1:0]];
      valid_rd_r <= valid_r[idx_r[AW-1:0]];
      rd_idx_r   <= idx_r[AW-1:0];
    end
  end

  // Request capture, result build and output register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_r <= mrt_pkg::req_type_t'(in_req_type);
      pfn_r      <= in_pfn;
      hi_raw_r   <= in_addr + {{(AD_W-mrt_pkg::SIZE_W){1'b0}}, in_size};
    end
    if (cmd.accept && quick_req) begin
      res_status_r <= quick_status;
      res_mmio_r   <= 1'b0;
      res_group_r  <= '0;
      res_v_r      <= '0;
      res_r_r      <= '0;
    end else if (scan_hit || scan_miss) begin
      res_status_r <= scan_status;
      if (req_type_r == mrt_pkg::REQ_XLATE) begin
        res_mmio_r  <= scan_hit;
        res_group_r <= {hash, 3'b000};
        res_v_r     <= {pfn_r[PFN_W-1:11], 6'b000000, 1'b1};
        res_r_r     <= {pfn_r, 6'b000000,
                        scan_hit ? mrt_pkg::WIMG_MMIO : mrt_pkg::WIMG_CACHED, 3'b000};
      end else begin
        res_mmio_r  <= 1'b0;
        res_group_r <= '0;
        res_v_r     <= '0;
        res_r_r     <= '0;
      end
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_mmio_r   <= res_mmio_r;
      out_group_r  <= res_group_r;
      out_v_r      <= res_v_r;
      out_r_r      <= res_r_r;
    end
  end

  assign out_status    = out_status_r;
  assign out_is_mmio   = out_mmio_r;
  assign out_pteg_slot = out_group_r;
  assign out_hpte_v    = out_v_r;
  assign out_hpte_r    = out_r_r;

endmodule

`default_nettype wire

// File: rtl/mmio_region_table_htab_entry.sv
// MMIO region table with hashed page table entry builder.
//
// in_chan takes one request item (add, delete, clear, translate) and out_chan
// returns exactly one result item per request, in order. cfg_chan writes the
// MMU enable bit; it is ready outside reset and should only be written while
// no request is in flight.
//
// Add, delete and translate walk the table one slot per cycle through a single
// read port of the region memory and stop at the first matching slot, or after
// the last slot when nothing matches. Clear, rejected arguments and translate
// while disabled are answered without a walk. Each result is built in a held
// result register and moves to the output register once that register is
// free. The next request is taken only after the previous result has moved
// on to the output register.
//
// A finished result waits in the output register while the receiver stalls,
// and a new request is still accepted; its own result is held until the
// output register is taken. Reset empties the table at once through the
// per-slot valid bits and clears the MMU enable bit.

`default_nettype none

module mmio_region_table_htab_entry #(
  parameter int unsigned NUM_REGIONS = mrt_pkg::NUM_REGIONS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mrt_req_if.sink   in_chan,
  mrt_rsp_if.source out_chan,
  mrt_cfg_if.sink   cfg_chan
);

  mrt_pkg::cmd_t  cmd;
  mrt_pkg::stat_t stat;

  assign cfg_chan.ready = rst_n;

  // Sequencer.
  mrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Region store, comparators and entry builder.
  mrt_dpath #(
    .NUM_REGIONS (NUM_REGIONS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_chan.req_type),
    .in_addr         (in_chan.addr),
    .in_size         (in_chan.size),
    .cfg_we          (cfg_chan.valid),
    .cfg_mmu_enabled (cfg_chan.mmu_enabled),
    .out_status      (out_chan.status),
    .out_is_mmio     (out_chan.is_mmio),
    .out_pteg_slot   (out_chan.pteg_slot),
    .out_hpte_v      (out_chan.hpte_v),
    .out_hpte_r      (out_chan.hpte_r)
  );

  // A walk ends either with a hit or a miss, never both.
  a_hit_miss_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.hit && stat.miss))
    else $error("table walk reported hit and miss together");

  // No request is taken while a walk is running.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> !in_chan.ready)
    else $error("request channel ready during table walk");

  // A request answered without a walk never starts one.
  a_quick_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && stat.quick) |=> !cmd.scan)
    else $error("walk started for a request answered directly");

  // A new result only appears after the controller loaded the output register.
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.load_out))
    else $error("result valid without an output load");

endmodule

`default_nettype wire
